[rtl/sdd_pkg.sv]
// Package for the shuffled deck dealer: sizes, constants and shared types.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
package sdd_pkg;
	localparam int DECK_SIZE = 1024;
	localparam int DECK_W = $clog2(DECK_SIZE);
	localparam int POS_W = DECK_W + 1;
	localparam int MAX_CANDIDATES = 64;
	localparam int CAND_W = 7;
	localparam int VICT_W = 6;
	localparam int CARD_W = 10;
	localparam logic [63:0] STUCK_STATE = 64'h1234567890abcdef;
	localparam logic [63:0] SEED_FALLBACK = 64'h9e3779b97f4a7c15;

	// Request to the shared restoring divider.
	typedef struct packed {
		logic start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	// Status back from the divider.
	typedef struct packed {
		logic done;
		logic [63:0] remainder;
	} div_rsp_t;

	// One xorshift64 step.
	function automatic logic [63:0] xorshift(input logic [63:0] s);
		logic [63:0] x;
		x = s ^ (s << 13);
		x = x ^ (x >> 7);
		x = x ^ (x << 17);
		return x;
	endfunction
endpackage

[rtl/sdd_divider.sv]
// Shared radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on sdd_pkg for the request and response structs.
`timescale 1ns / 1ps
module sdd_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  sdd_pkg::div_req_t req,
	output sdd_pkg::div_rsp_t rsp
);
	logic [63:0] rem_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	// Shift in the next dividend bit and try a subtraction.
	assign trial = {rem_q, num_q[63]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			if (!trial[64]) rem_q <= trial[63:0];
			else rem_q <= {rem_q[62:0], num_q[63]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.remainder = rem_q;
endmodule

[rtl/sdd_deck_ram.sv]
// Deck memory: one write and one registered read port.
// Depends on sdd_pkg for the deck size and card width.
`timescale 1ns / 1ps
module sdd_deck_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sdd_pkg::DECK_W-1:0] waddr,
	input  logic [sdd_pkg::CARD_W-1:0] wdata,
	input  logic [sdd_pkg::DECK_W-1:0] raddr,
	output logic [sdd_pkg::CARD_W-1:0] rdata
);
	logic [sdd_pkg::CARD_W-1:0] mem [sdd_pkg::DECK_SIZE];

	// Read data registered; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/shuffled_deck_dealer.sv]
// Shuffled deck dealer top level: sequencer, generator and result register.
// Depends on sdd_pkg, sdd_divider and sdd_deck_ram.
`timescale 1ns / 1ps
// A request reads the next card from the deck memory, then the shared remainder
// unit reduces it modulo the candidate count, then the result beat is loaded.
// A zero candidate count skips the reduction.
// The first request after reset also fills the deck and shuffles it; a shuffle,
// also run whenever 1024 cards have been dealt, makes 1023 swaps, each waiting
// on the shared remainder unit and the deck memory. The seed is taken at the
// first request only.
module shuffled_deck_dealer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [63:0] seed_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata, // [6:0] candidate_count
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata  // [9:0] card, [15:10] victim_index, [79:16] deals_total
);
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_FILL  = 11'b00000000010,
		ST_GEN   = 11'b00000000100,
		ST_DIV   = 11'b00000001000,
		ST_RDI   = 11'b00000010000,
		ST_RDJ   = 11'b00000100000,
		ST_WRI   = 11'b00001000000,
		ST_WRJ   = 11'b00010000000,
		ST_RDC   = 11'b00100000000,
		ST_VIC   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	localparam int DW = sdd_pkg::DECK_W;
	localparam int PW = sdd_pkg::POS_W;

	state_t state_q;
	logic [63:0] seed_q, prng_q, deals_q;
	logic primed_q;
	logic [PW-1:0] pos_q;
	logic [DW-1:0] i_q, j_q, fill_q;
	logic [sdd_pkg::CARD_W-1:0] vi_q, card_q;
	logic [sdd_pkg::CAND_W-1:0] cnt_q;
	logic [1:0] wait_q;
	logic out_v_q;
	logic [79:0] out_q;
	logic [63:0] x;
	sdd_pkg::div_req_t dreq;
	sdd_pkg::div_rsp_t drsp;
	logic we;
	logic [DW-1:0] waddr, raddr;
	logic [sdd_pkg::CARD_W-1:0] wdata, rdata;

	sdd_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	sdd_deck_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata));

	assign x = sdd_pkg::xorshift(prng_q);
	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	// Memory port and divider request selection.
	always_comb begin
		we = 1'b0;
		waddr = i_q;
		wdata = vi_q;
		raddr = i_q;
		dreq.start = 1'b0;
		dreq.dividend = x;
		dreq.divisor = {{(64-DW-1){1'b0}}, {1'b0, i_q} + {{DW{1'b0}}, 1'b1}};
		case (state_q)
			ST_FILL: begin
				we = 1'b1;
				waddr = fill_q;
				wdata = fill_q;
			end
			ST_GEN: dreq.start = 1'b1;
			ST_RDJ: raddr = j_q;
			ST_WRI: begin
				we = 1'b1;
				waddr = i_q;
				wdata = rdata;
			end
			ST_WRJ: begin
				we = 1'b1;
				waddr = j_q;
				wdata = vi_q;
			end
			ST_RDC: raddr = pos_q[DW-1:0];
			ST_VIC: begin
				dreq.start = (wait_q == 2'd1);
				dreq.dividend = {54'd0, card_q};
				dreq.divisor = {57'd0, cnt_q};
			end
			default: ;
		endcase
	end

	// Seed register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (seed_we) seed_q <= seed_wdata;
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			primed_q <= 1'b0;
			pos_q <= '0;
			prng_q <= '0;
			deals_q <= '0;
			out_v_q <= 1'b0;
			fill_q <= '0;
			i_q <= '0;
			wait_q <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					if (s_tdata[6:0] > 7'(sdd_pkg::MAX_CANDIDATES))
						cnt_q <= 7'(sdd_pkg::MAX_CANDIDATES);
					else cnt_q <= s_tdata[6:0];
					if (!primed_q) begin
						fill_q <= '0;
						prng_q <= (seed_q != 64'd0) ? seed_q : sdd_pkg::SEED_FALLBACK;
						state_q <= ST_FILL;
					end else if (pos_q[DW]) begin
						i_q <= '1;
						state_q <= ST_GEN;
					end else state_q <= ST_RDC;
				end
				ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (&fill_q) begin
						primed_q <= 1'b1;
						i_q <= '1;
						state_q <= ST_GEN;
					end
				end
				ST_GEN: begin
					prng_q <= (x != 64'd0) ? x : sdd_pkg::STUCK_STATE;
					state_q <= ST_DIV;
				end
				ST_DIV: if (drsp.done) begin
					j_q <= drsp.remainder[DW-1:0];
					state_q <= ST_RDI;
				end
				ST_RDI: state_q <= ST_RDJ;
				ST_RDJ: begin
					vi_q <= rdata;
					state_q <= ST_WRI;
				end
				ST_WRI: state_q <= ST_WRJ;
				ST_WRJ: begin
					if (i_q == DW'(1)) begin
						pos_q <= '0;
						state_q <= ST_RDC;
					end else begin
						i_q <= i_q - 1'b1;
						state_q <= ST_GEN;
					end
				end
				ST_RDC: begin
					wait_q <= 2'd0;
					state_q <= ST_VIC;
				end
				ST_VIC: begin
					if (wait_q == 2'd0) begin
						card_q <= rdata;
						wait_q <= (cnt_q == 7'd0) ? 2'd2 : 2'd1;
					end else if (wait_q == 2'd1) begin
						wait_q <= 2'd3;
					end else if (wait_q == 2'd2 || drsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_v_q) begin
					out_v_q <= 1'b1;
					out_q <= {deals_q + 64'd1,
						(cnt_q == 7'd0) ? 6'd0 : drsp.remainder[5:0], card_q};
					deals_q <= deals_q + 64'd1;
					pos_q <= pos_q + 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The output holds while a beat is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");
	// No input is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted with result pending");
	// The deal position never passes the deck size.
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(sdd_pkg::DECK_SIZE))
		else $error("deal position overflow");
endmodule

[tb/sv/shuffled_deck_dealer_test.sv]
// Self-checking testbench for the shuffled deck dealer: predicts each dealt card,
// victim index and deal count from its own copy of the deck and generator.
// Depends on sdd_pkg and the shuffled_deck_dealer RTL.
`timescale 1ns / 1ps
module shuffled_deck_dealer_test;
	localparam int STOP_CYCLES = 3000000;

	typedef struct packed {
		logic [63:0] deals;
		logic [5:0]  victim;
		logic [9:0]  card;
	} deal_t;

	logic        clk;
	logic        arst_n;
	logic        seed_we;
	logic [63:0] seed_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;

	shuffled_deck_dealer u_dut (
		.clk(clk), .arst_n(arst_n), .seed_we(seed_we), .seed_wdata(seed_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Predictor state.
	logic [9:0]  pred_deck [sdd_pkg::DECK_SIZE];
	logic        pred_primed;
	int unsigned pred_pos;
	logic [63:0] pred_rng;
	logic [63:0] pred_deals;
	logic [63:0] pred_seed;

	logic [7:0]  pending_counts[$];
	logic [7:0]  directed_counts [10];
	deal_t       expected_deals[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off_cycles;
	int          errors;
	int          cycles;
	int          dealt;

	function automatic logic [63:0] rng_step();
		logic [63:0] x;
		x = pred_rng;
		x = x ^ (x << 13);
		x = x ^ (x >> 7);
		x = x ^ (x << 17);
		pred_rng = (x != 0) ? x : sdd_pkg::STUCK_STATE;
		return x;
	endfunction

	function automatic void shuffle_deck();
		int unsigned j;
		logic [9:0] t;
		for (int unsigned i = sdd_pkg::DECK_SIZE - 1; i > 0; i--) begin
			j = int'(rng_step() % 64'(i + 1));
			t = pred_deck[i];
			pred_deck[i] = pred_deck[j];
			pred_deck[j] = t;
		end
		pred_pos = 0;
	endfunction

	// Work out the deal that one request causes.
	function automatic deal_t predict_deal(logic [7:0] req);
		deal_t d;
		logic [6:0] n;
		if (!pred_primed) begin
			for (int i = 0; i < sdd_pkg::DECK_SIZE; i++)
				pred_deck[i] = 10'(i);
			pred_deals = 0;
			pred_rng = (pred_seed != 0) ? pred_seed : sdd_pkg::SEED_FALLBACK;
			shuffle_deck();
			pred_primed = 1'b1;
		end
		if (pred_pos >= sdd_pkg::DECK_SIZE)
			shuffle_deck();
		d.card = pred_deck[pred_pos];
		pred_pos++;
		pred_deals++;
		n = req[6:0];
		if (n > 7'(sdd_pkg::MAX_CANDIDATES))
			n = 7'(sdd_pkg::MAX_CANDIDATES);
		d.victim = (n != 0) ? 6'({1'b0, d.card} % {4'b0, n}) : 6'd0;
		d.deals = pred_deals;
		return d;
	endfunction

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Driver: offers queued requests, idling at the current rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_deals.push_back(predict_deal(s_tdata));
				void'(pending_counts.pop_front());
			end
			if ((!s_tvalid || s_tready) && pending_counts.size() > 0 &&
			    ($urandom_range(99) >= send_idle_pct)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_counts[0];
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compares each result beat with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		deal_t got;
		deal_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				dealt++;
				if (expected_deals.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat %h", $time, m_tdata);
				end else begin
					want = expected_deals.pop_front();
					if (got.card !== want.card) begin
						errors++;
						$display("%0t: card expected %0d actual %0d", $time,
						         want.card, got.card);
					end
					if (got.victim !== want.victim) begin
						errors++;
						$display("%0t: victim expected %0d actual %0d", $time,
						         want.victim, got.victim);
					end
					if (got.deals !== want.deals) begin
						errors++;
						$display("%0t: deals expected %0d actual %0d", $time,
						         want.deals, got.deals);
					end
				end
			end
			if (hold_off_cycles > 0)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk)
		if (hold_off_cycles > 0)
			hold_off_cycles <= hold_off_cycles - 1;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > STOP_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_counts.size() > 0 || s_tvalid || expected_deals.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] value);
		@(posedge clk);
		seed_we <= 1'b1;
		seed_wdata <= value;
		pred_seed = value;
		@(posedge clk);
		seed_we <= 1'b0;
	endtask

	task automatic run_phase(int count, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < count; k++)
			if ($urandom_range(9) == 0)
				pending_counts.push_back(8'($urandom_range(127)));
			else
				pending_counts.push_back(8'($urandom_range(64, 1)));
		wait_drained();
	endtask

	initial begin
		seed_we = 1'b0;
		seed_wdata = '0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		errors = 0;
		cycles = 0;
		dealt = 0;
		pred_primed = 1'b0;
		pred_pos = 0;
		pred_rng = '0;
		pred_deals = '0;
		pred_seed = '0;
		directed_counts = '{8'd0, 8'd1, 8'd2, 8'd63, 8'd64, 8'd65, 8'd127,
		                    8'd100, 8'd7, 8'd33};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// A random seed before priming; later writes must have no effect.
		write_seed({$urandom, $urandom});

		// Directed: extremes and saturation of the candidate count.
		foreach (directed_counts[i])
			pending_counts.push_back(directed_counts[i]);
		wait_drained();

		// Ignored seed writes: zero and all ones, between phases.
		write_seed('0);
		run_phase(200, 0, 0);
		write_seed('1);
		run_phase(150, 75, 0);

		// Long hold-off while requests keep coming, so the input stalls.
		hold_off_cycles = 2000;
		run_phase(100, 0, 75);
		write_seed({$urandom, $urandom});
		run_phase(150, 12, 12);
		run_phase(150, 0, 0);

		$display("Dealt %0d cards from the primed deck, with seed writes after priming,",
		         dealt);
		$display("saturated and zero candidate counts, and idle and stall phases.");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[shuffled_deck_dealer.f]
rtl/sdd_pkg.sv
rtl/sdd_divider.sv
rtl/sdd_deck_ram.sv
rtl/shuffled_deck_dealer.sv
tb/sv/shuffled_deck_dealer_test.sv
